### hdl/span_range_edit_tracker_top_defines.svh
// assertion macros shared by the range tracker rtl
`ifndef SPAN_RANGE_EDIT_TRACKER_TOP_DEFINES_SVH
`define SPAN_RANGE_EDIT_TRACKER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define SRET_ASSERT_NOW(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("range tracker check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define SRET_ASSERT_NEXT(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("range tracker check failed");

`endif

### hdl/sret_pkg.sv
// types and constants of the range tracker
package sret_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int POSITION_BITS_DEF = 20;
	localparam int TAG_BITS          = 16;
	localparam int STATUS_BITS       = 2;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_EDIT   = 2'd2,
		KIND_DUMP   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_BITS-1:0] {
		STATUS_OK   = 2'd0,
		STATUS_FULL = 2'd1,
		STATUS_SAT  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EDIT,
		ST_DUMP,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic del;
		logic sat;
	} edit_flags_t;

endpackage

### hdl/sret_ifs.sv
// valid/ready channels of the range tracker: command beats in, result beats out
interface sret_in_if #(
	parameter int PosW = 20
);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    kind;
	logic [sret_pkg::TAG_BITS-1:0] span_tag;
	logic [PosW-1:0]               first_position;
	logic [PosW-1:0]               second_value;
	logic [PosW-1:0]               inserted_length;
	logic                          replacement_flag;

	modport source (
		output valid, kind, span_tag, first_position, second_value, inserted_length,
			replacement_flag,
		input  ready
	);
	modport sink (
		input  valid, kind, span_tag, first_position, second_value, inserted_length,
			replacement_flag,
		output ready
	);
endinterface

interface sret_out_if #(
	parameter int PosW = 20,
	parameter int CntW = 5
);
	logic                             valid;
	logic                             ready;
	logic [sret_pkg::TAG_BITS-1:0]    result_tag;
	logic [PosW-1:0]                  result_start;
	logic [PosW-1:0]                  result_end;
	logic                             result_replacement;
	logic                             entry_valid;
	logic                             last;
	logic [CntW-1:0]                  entry_count;
	logic [sret_pkg::STATUS_BITS-1:0] status;

	modport source (
		output valid, result_tag, result_start, result_end, result_replacement, entry_valid,
			last, entry_count, status,
		input  ready
	);
	modport sink (
		input  valid, result_tag, result_start, result_end, result_replacement, entry_valid,
			last, entry_count, status,
		output ready
	);
endinterface

### hdl/sret_ram.sv
// generic single-port-write, single-port-read ram with registered read
module sret_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		// read data holds while no read is issued
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/sret_edit.sv
// applies one edit (removal, then insertion) to a single table entry
module sret_edit #(
	parameter int PosW = 20
) (
	input  logic                     rep,
	input  logic [PosW-1:0]          start_in,
	input  logic [PosW-1:0]          end_in,
	input  logic [PosW-1:0]          edit_start,
	input  logic [PosW-1:0]          removed,
	input  logic [PosW-1:0]          inserted,
	output logic [PosW-1:0]          start_out,
	output logic [PosW-1:0]          end_out,
	output sret_pkg::edit_flags_t    flags
);
	import sret_pkg::*;

	localparam int W = PosW + 1;
	localparam logic [W-1:0] POS_MAX = {1'b0, {PosW{1'b1}}};

	logic [W-1:0] es_x;
	logic [W-1:0] rem_x;
	logic [W-1:0] ins_x;
	logic [W-1:0] rend;
	logic [W-1:0] s0;
	logic [W-1:0] e0;
	logic [W-1:0] s1;
	logic [W-1:0] e1;
	logic [W-1:0] s_plus;
	logic [W-1:0] e_plus;
	logic [W-1:0] s2;
	logic [W-1:0] e2;
	logic         del;
	logic         sat;

	assign es_x  = {1'b0, edit_start};
	assign rem_x = {1'b0, removed};
	assign ins_x = {1'b0, inserted};
	assign rend  = es_x + rem_x;
	assign s0    = {1'b0, start_in};
	assign e0    = {1'b0, end_in};

	// removal step
	always_comb begin
		s1  = s0;
		e1  = e0;
		del = 1'b0;
		sat = 1'b0;
		if (rem_x != '0) begin
			priority if (rep && (es_x < e0) && (s0 < rend)) begin
				del = 1'b1;
			end else if (e0 <= es_x) begin
				s1 = s0;
			end else if (s0 >= rend) begin
				s1 = s0 - rem_x;
				if (e0 < rem_x) begin
					e1  = '0;
					sat = 1'b1;
				end else begin
					e1 = e0 - rem_x;
				end
			end else begin
				s1 = (s0 < es_x) ? s0 : es_x;
				e1 = (e0 <= rend) ? es_x : (e0 - rem_x);
				if (s1 >= e1) begin
					del = 1'b1;
				end
			end
		end
		// insertion step
		s_plus = s1 + ins_x;
		e_plus = e1 + ins_x;
		s2     = s1;
		e2     = e1;
		if ((ins_x != '0) && !del) begin
			priority if ((es_x == '0) && (s1 == '0) && !rep) begin
				e2 = e_plus;
			end else if (es_x <= s1) begin
				s2 = s_plus;
				e2 = e_plus;
			end else if (!rep && (es_x <= e1)) begin
				e2 = e_plus;
			end else begin
				e2 = e1;
			end
		end
		if (s2 > POS_MAX) begin
			s2  = POS_MAX;
			sat = 1'b1;
		end
		if (e2 > POS_MAX) begin
			e2  = POS_MAX;
			sat = 1'b1;
		end
	end

	assign start_out = s2[PosW-1:0];
	assign end_out   = e2[PosW-1:0];
	assign flags     = '{del: del, sat: sat && !del};

endmodule

### hdl/span_range_edit_tracker_top.sv
// range tracker top level: command decode, table walk sequencer and result register
//
//  channel  | dir | beat carries
//  ---------+-----+-------------------------------------------------------------
//  in_ch    | in  | kind, span_tag, first_position, second_value, inserted_length,
//           |     | replacement_flag
//  out_ch   | out | result_tag/start/end/replacement, entry_valid, last, entry_count,
//           |     | status
//
// the one-read one-write table ram visits one entry per cycle while the sink does
// not stall; one command is in flight at a time.
// reset clears the entry count and control state, not the table; table contents are never swept.
// a stalled sink holds the result register and pauses a dump in place.
`include "span_range_edit_tracker_top_defines.svh"

module span_range_edit_tracker_top #(
	parameter int TABLE_ENTRIES = sret_pkg::TABLE_ENTRIES_DEF,
	parameter int POSITION_BITS = sret_pkg::POSITION_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	sret_in_if.sink    in_ch,
	sret_out_if.source out_ch
);
	import sret_pkg::*;

	localparam int AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int WORD  = TAG_BITS + 2 * POSITION_BITS + 1;
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

	state_t state_q, state_d;

	logic [CNT_W-1:0]         used_q;
	logic [CNT_W-1:0]         rd_idx_q;
	logic [CNT_W-1:0]         wr_idx_q;
	logic [CNT_W-1:0]         idx_s1;
	logic                     pend_s1;
	logic                     sat_q;
	status_t                  status_q;
	logic [POSITION_BITS-1:0] es_q;
	logic [POSITION_BITS-1:0] rem_q;
	logic [POSITION_BITS-1:0] ins_q;

	logic                     out_valid_q;
	logic [TAG_BITS-1:0]      out_tag_q;
	logic [POSITION_BITS-1:0] out_start_q;
	logic [POSITION_BITS-1:0] out_end_q;
	logic                     out_rep_q;
	logic                     out_entry_q;
	logic                     out_last_q;
	logic [CNT_W-1:0]         out_count_q;
	logic [STATUS_BITS-1:0]   out_status_q;

	logic                     in_fire;
	logic                     out_free;
	logic                     table_full;
	logic                     walk_done;

	logic                     ram_wr_en;
	logic [AW-1:0]            ram_wr_addr;
	logic [WORD-1:0]          ram_wr_data;
	logic                     ram_rd_en;
	logic [AW-1:0]            ram_rd_addr;
	logic [WORD-1:0]          ram_rd_data;

	logic                     out_load;
	logic                     out_load_entry;
	logic                     out_load_last;

	logic [TAG_BITS-1:0]      rd_tag;
	logic [POSITION_BITS-1:0] rd_start;
	logic [POSITION_BITS-1:0] rd_end;
	logic                     rd_rep;
	logic [POSITION_BITS-1:0] ed_start;
	logic [POSITION_BITS-1:0] ed_end;
	edit_flags_t              ed_flags;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;
	assign table_full  = (used_q == FULL_COUNT);
	assign walk_done   = (rd_idx_q == used_q) && !pend_s1;

	assign {rd_tag, rd_start, rd_end, rd_rep} = ram_rd_data;

	sret_ram #(
		.WIDTH (WORD),
		.DEPTH (TABLE_ENTRIES),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	sret_edit #(
		.PosW (POSITION_BITS)
	) u_edit (
		.rep        (rd_rep),
		.start_in   (rd_start),
		.end_in     (rd_end),
		.edit_start (es_q),
		.removed    (rem_q),
		.inserted   (ins_q),
		.start_out  (ed_start),
		.end_out    (ed_end),
		.flags      (ed_flags)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					unique case (kind_t'(in_ch.kind))
						KIND_CLEAR:  state_d = ST_RESP;
						KIND_APPEND: state_d = ST_RESP;
						KIND_EDIT:   state_d = ST_EDIT;
						KIND_DUMP:   state_d = (used_q == '0) ? ST_RESP : ST_DUMP;
					endcase
				end
			end
			ST_EDIT: begin
				if (walk_done) begin
					state_d = ST_RESP;
				end
			end
			ST_DUMP: begin
				if (walk_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// memory and result-register controls
	always_comb begin
		ram_wr_en      = 1'b0;
		ram_wr_addr    = wr_idx_q[AW-1:0];
		ram_wr_data    = {rd_tag, ed_start, ed_end, rd_rep};
		ram_rd_en      = 1'b0;
		ram_rd_addr    = rd_idx_q[AW-1:0];
		out_load       = 1'b0;
		out_load_entry = 1'b0;
		out_load_last  = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && (kind_t'(in_ch.kind) == KIND_APPEND) && !table_full) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = used_q[AW-1:0];
					ram_wr_data = {in_ch.span_tag, in_ch.first_position, in_ch.second_value,
						in_ch.replacement_flag};
				end
			end
			ST_EDIT: begin
				// writes trail reads, so the write index never reaches an unread entry
				ram_rd_en = (rd_idx_q != used_q);
				ram_wr_en = pend_s1 && !ed_flags.del;
			end
			ST_DUMP: begin
				out_load       = pend_s1 && out_free;
				out_load_entry = 1'b1;
				out_load_last  = ((idx_s1 + CNT_W'(1)) == used_q);
				ram_rd_en      = (rd_idx_q != used_q) && (!pend_s1 || out_load);
			end
			ST_RESP: begin
				out_load = out_free;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			idx_s1      <= '0;
			pend_s1     <= 1'b0;
			sat_q       <= 1'b0;
			status_q    <= STATUS_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					rd_idx_q <= '0;
					wr_idx_q <= '0;
					pend_s1  <= 1'b0;
					sat_q    <= 1'b0;
					if (in_fire) begin
						status_q <= STATUS_OK;
						unique case (kind_t'(in_ch.kind))
							KIND_CLEAR: begin
								used_q <= '0;
							end
							KIND_APPEND: begin
								if (table_full) begin
									status_q <= STATUS_FULL;
								end else begin
									used_q <= used_q + CNT_W'(1);
								end
							end
							KIND_EDIT: begin
								used_q <= used_q;
							end
							KIND_DUMP: begin
								used_q <= used_q;
							end
						endcase
					end
				end
				ST_EDIT: begin
					pend_s1 <= ram_rd_en;
					if (ram_rd_en) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (ram_wr_en) begin
						wr_idx_q <= wr_idx_q + CNT_W'(1);
					end
					if (pend_s1 && ed_flags.sat) begin
						sat_q <= 1'b1;
					end
					if (walk_done) begin
						used_q   <= wr_idx_q;
						status_q <= sat_q ? STATUS_SAT : STATUS_OK;
					end
				end
				ST_DUMP: begin
					if (ram_rd_en) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
						idx_s1   <= rd_idx_q;
						pend_s1  <= 1'b1;
					end else if (out_load) begin
						pend_s1 <= 1'b0;
					end
				end
				ST_RESP: begin
					pend_s1 <= 1'b0;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// command operands and result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			es_q  <= in_ch.first_position;
			rem_q <= in_ch.second_value;
			ins_q <= in_ch.inserted_length;
		end
		if (out_load) begin
			out_entry_q <= out_load_entry;
			out_last_q  <= out_load_last;
			out_count_q <= used_q;
			if (out_load_entry) begin
				out_tag_q    <= rd_tag;
				out_start_q  <= rd_start;
				out_end_q    <= rd_end;
				out_rep_q    <= rd_rep;
				out_status_q <= STATUS_OK;
			end else begin
				out_tag_q    <= '0;
				out_start_q  <= '0;
				out_end_q    <= '0;
				out_rep_q    <= 1'b0;
				out_status_q <= status_q;
			end
		end
	end

	assign out_ch.valid              = out_valid_q;
	assign out_ch.result_tag         = out_tag_q;
	assign out_ch.result_start       = out_start_q;
	assign out_ch.result_end         = out_end_q;
	assign out_ch.result_replacement = out_rep_q;
	assign out_ch.entry_valid        = out_entry_q;
	assign out_ch.last               = out_last_q;
	assign out_ch.entry_count        = out_count_q;
	assign out_ch.status             = out_status_q;

	`SRET_ASSERT_NOW(a_count_bound, 1'b1, used_q <= FULL_COUNT)
	`SRET_ASSERT_NOW(a_write_trails_read, state_q == ST_EDIT, wr_idx_q <= rd_idx_q)
	`SRET_ASSERT_NEXT(a_one_command, in_fire, !in_ch.ready)

endmodule
